// ----- sv/npc_pkg.sv -----
// Shared types, constants and grid tables for the nearest palette color search.
package npc_pkg;

	localparam int DEF_PALETTE_SIZE = 256;
	localparam int CHAN_W           = 8;
	localparam int IDX_W            = 8;
	localparam int DIST_W           = 18;
	localparam int CHAN_MAX         = 255;
	localparam int RB_STEPS         = 11;
	localparam int G_STEPS          = 23;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [CHAN_W-1:0] grid_lut_t [2**CHAN_W];

	// Beat payload handed from cell to cell along the chain
	typedef struct packed {
		logic              query;
		logic [IDX_W-1:0]  idx;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} npc_beat_t;

	// Red/blue grid: quantize to 12 levels and rebuild
	function automatic grid_lut_t build_grid_rb();
		grid_lut_t lut;
		for (int i = 0; i < 2**CHAN_W; i++) begin
			lut[i] = CHAN_W'((((i * RB_STEPS) / CHAN_MAX) * CHAN_MAX) / RB_STEPS);
		end
		return lut;
	endfunction

	// Green grid: quantize to 24 levels and rebuild
	function automatic grid_lut_t build_grid_g();
		grid_lut_t lut;
		for (int i = 0; i < 2**CHAN_W; i++) begin
			lut[i] = CHAN_W'((((i * G_STEPS) / CHAN_MAX) * CHAN_MAX) / G_STEPS);
		end
		return lut;
	endfunction

	localparam grid_lut_t GRID_RB = build_grid_rb();
	localparam grid_lut_t GRID_G  = build_grid_g();

endpackage

// ----- sv/npc_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface npc_req_if import npc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [IDX_W-1:0]  entry_index;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, req_type, entry_index, red, green, blue, input ready);
	modport sink (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if import npc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  palette_index;
	logic [DIST_W-1:0] distance;

	modport source (output valid, palette_index, distance, input ready);
	modport sink (input valid, palette_index, distance, output ready);
endinterface

// ----- sv/npc_cell.sv -----
// One chain cell: holds a palette entry, scores passing queries against it.
module npc_cell import npc_pkg::*; #(
	parameter int CELL_INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      valid_i,
	input  npc_beat_t beat_i,
	output logic      valid_o,
	output npc_beat_t beat_o
);

	logic [3*CHAN_W-1:0] entry_q;
	logic                valid_q;
	npc_beat_t           beat_q;
	npc_beat_t           beat_nxt;
	logic [CHAN_W-1:0]   diff_r, diff_g, diff_b;
	logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]   dist_sum;
	logic                hit_load;

	// Distance from the grid color to the stored entry
	always_comb begin
		diff_r = (beat_i.red >= entry_q[3*CHAN_W-1:2*CHAN_W])
			? beat_i.red - entry_q[3*CHAN_W-1:2*CHAN_W]
			: entry_q[3*CHAN_W-1:2*CHAN_W] - beat_i.red;
		diff_g = (beat_i.green >= entry_q[2*CHAN_W-1:CHAN_W])
			? beat_i.green - entry_q[2*CHAN_W-1:CHAN_W]
			: entry_q[2*CHAN_W-1:CHAN_W] - beat_i.green;
		diff_b = (beat_i.blue >= entry_q[CHAN_W-1:0])
			? beat_i.blue - entry_q[CHAN_W-1:0]
			: entry_q[CHAN_W-1:0] - beat_i.blue;
		sq_r = diff_r * diff_r;
		sq_g = diff_g * diff_g;
		sq_b = diff_b * diff_b;
		dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
	end

	// Keep the running best; strict compare leaves ties with the lower index
	always_comb begin
		beat_nxt = beat_i;
		if (beat_i.query && (dist_sum < beat_i.best_dist)) begin
			beat_nxt.best_dist = dist_sum;
			beat_nxt.best_idx  = IDX_W'(CELL_INDEX);
		end
	end

	assign hit_load = valid_i && (beat_i.query == REQ_LOAD) && (beat_i.idx == IDX_W'(CELL_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q <= beat_nxt;
			if (hit_load) begin
				entry_q <= {beat_i.red, beat_i.green, beat_i.blue};
			end
		end
	end

	assign valid_o = valid_q;
	assign beat_o  = beat_q;

endmodule

// ----- sv/nearest_palette_color_search_unit.sv -----
// Top level: grid quantizer feeding a chain of palette cells.
//
// Usage: beats arrive on req (valid/ready). A load beat (req_type 0) writes
// red/green/blue into palette entry entry_index; indices at or beyond
// PALETTE_SIZE are dropped. A query beat (req_type 1) snaps its color to the
// 12x24x12 grid and returns on rsp the lowest-index nearest entry and its
// squared distance. Loads return nothing.
// Each beat enters a head register, then, while the chain advances, walks one
// cell per cycle down a chain of PALETTE_SIZE cells, each cell holding one
// entry. Loads and queries travel in the same chain, so every query sees
// exactly the loads accepted before it. A query passes the head register and
// then each cell register in order, the last driving rsp; one beat per cycle
// is accepted while the chain advances, set by the one-cell-per-cycle step.
// The last cell output is the response register. When a query sits there and
// rsp.ready is low, the whole chain holds and req.ready drops; bubbles and
// loads at the end of the chain never block it.
// Reset clears all valid flags; palette contents are undefined until loaded,
// and every entry must be loaded before a query is issued.
module nearest_palette_color_search_unit import npc_pkg::*; #(
	parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
	input  logic  clk,
	input  logic  arst_n,
	npc_req_if.sink   req,
	npc_rsp_if.source rsp
);

	logic      advance;
	logic      head_valid_s1;
	npc_beat_t head_s1;
	npc_beat_t head_nxt;
	logic      chain_valid [PALETTE_SIZE+1];
	npc_beat_t chain_beat  [PALETTE_SIZE+1];

	// Chain moves unless an unread query result sits at the end
	assign advance   = !(chain_valid[PALETTE_SIZE] && chain_beat[PALETTE_SIZE].query
		&& !rsp.ready);
	assign req.ready = advance;

	// Head stage: grid lookup for queries, raw color for loads
	always_comb begin
		head_nxt.query     = req.req_type;
		head_nxt.idx       = req.entry_index;
		head_nxt.best_idx  = '0;
		head_nxt.best_dist = '1;
		if (req.req_type == REQ_QUERY) begin
			head_nxt.red   = GRID_RB[req.red];
			head_nxt.green = GRID_G[req.green];
			head_nxt.blue  = GRID_RB[req.blue];
		end else begin
			head_nxt.red   = req.red;
			head_nxt.green = req.green;
			head_nxt.blue  = req.blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s1 <= 1'b0;
		end else if (advance) begin
			head_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			head_s1 <= head_nxt;
		end
	end

	assign chain_valid[0] = head_valid_s1;
	assign chain_beat[0]  = head_s1;

	// Cell chain, one palette entry per cell
	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
		npc_cell #(
			.CELL_INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_i (chain_valid[i]),
			.beat_i  (chain_beat[i]),
			.valid_o (chain_valid[i+1]),
			.beat_o  (chain_beat[i+1])
		);
	end

	// Response from the last cell
	assign rsp.valid         = chain_valid[PALETTE_SIZE] && chain_beat[PALETTE_SIZE].query;
	assign rsp.palette_index = chain_beat[PALETTE_SIZE].best_idx;
	assign rsp.distance      = chain_beat[PALETTE_SIZE].best_dist;

endmodule
